/* rtl/core/tccs_pkg.sv */
// Shared types and constants for the text console cursor/scroll core.
// No dependencies.
package tccs_pkg;

    localparam int POS_W  = 11;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'd0;

    typedef enum logic [1:0] {
        KIND_PUT  = 2'd0,
        KIND_SET  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] character;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [BYTE_W-1:0] cell_data;
        logic              scrolled;
        logic              bad_position;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_READ,
        ST_SHIFT,
        ST_ZERO,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/tccs_screen_ram.sv */
// Screen cell store: one write port, one read port, registered read data.
// Depends on tccs_pkg.
module tccs_screen_ram
    import tccs_pkg::*;
#(
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tccs_col_split.sv */
// Column of a cell index: position mod COLUMNS by reciprocal multiply, two stages.
// Depends on tccs_pkg.
module tccs_col_split
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    localparam int CLW = $clog2(COLUMNS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [POS_W-1:0] i_position,
    output logic             o_done,
    output logic [CLW-1:0]   o_col
);

    localparam int SH   = POS_W + CLW;
    localparam int MW   = POS_W + 2;
    localparam int PW   = SH + POS_W;
    localparam int MULT = ((1 << SH) + COLUMNS - 1) / COLUMNS;
    localparam logic [MW-1:0] MULT_V = MW'(MULT);

    logic             r_v1;
    logic             r_v2;
    logic [PW-1:0]    r_prod;
    logic [POS_W-1:0] r_pos1;
    logic [CLW-1:0]   r_col;

    logic [POS_W-1:0]   quot;
    logic [2*POS_W-1:0] qc_full;
    logic [POS_W-1:0]   rem;

    assign quot    = r_prod[SH +: POS_W];
    assign qc_full = {{POS_W{1'b0}}, quot} * (2*POS_W)'(COLUMNS);
    assign rem     = r_pos1 - qc_full[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(i_position) * PW'(MULT_V);
            r_pos1 <= i_position;
        end
        if (r_v1) begin
            r_col <= rem[CLW-1:0];
        end
    end

    assign o_done = r_v2;
    assign o_col  = r_col;

endmodule

/* rtl/core/text_console_cursor_scroll_core.sv */
// Top level of the text console core: sequencer, cursor registers, output register.
// Depends on tccs_pkg, tccs_screen_ram and tccs_col_split.
//
// One item at a time. A put item goes from accept straight to the result state, a read
// item first passes through a registered screen memory read, a set-cursor item waits on
// the two-stage column split, and any out-of-range or unused-kind item goes straight to
// the result state. A put that scrolls adds a pass over the screen memory: it moves rows
// up through its one read port and one write port, then blanks the bottom row. After
// reset the core clears the screen before it accepts its first item. A new item can be
// accepted while the previous result is still waiting in the output register.
module text_console_cursor_scroll_core
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CLW        = $clog2(COLUMNS);
    localparam int SHIFT_N    = COLUMNS * (ROWS - 1);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]  SHIFT_END = AW'(SHIFT_N);
    localparam logic [AW-1:0]  BOTTOM    = AW'(SHIFT_N);
    localparam logic [CLW-1:0] LAST_COL  = CLW'(COLUMNS - 1);

    t_state r_state;
    t_state n_state;

    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_cur;
    logic [CLW-1:0]    r_col;
    logic [AW-1:0]     r_pos;
    logic [BYTE_W-1:0] r_data;
    logic              r_scr;
    logic              r_bad;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              accept;
    logic              out_load;
    logic              pos_ok;
    logic [AW-1:0]     pos_addr;
    logic [AW:0]       put_nxt;
    logic [CLW-1:0]    put_col;
    logic              put_scroll;
    logic              is_newline;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              split_start;
    logic              split_done;
    logic [CLW-1:0]    split_col;

    logic [AW+POS_W-1:0] pos_wide;
    logic [AW+POS_W-1:0] cur_wide;

    assign pos_wide   = {{AW{1'b0}}, i_in_item.position};
    assign pos_ok     = pos_wide < (AW+POS_W)'(CELL_COUNT);
    assign pos_addr   = pos_wide[AW-1:0];
    assign is_newline = i_in_item.character == NEWLINE_CHAR;
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        if (is_newline) begin
            put_nxt = {1'b0, r_cur} - {{(AW+1-CLW){1'b0}}, r_col} + (AW+1)'(COLUMNS);
            put_col = '0;
        end else begin
            put_nxt = {1'b0, r_cur} + (AW+1)'(1);
            put_col = (r_col == LAST_COL) ? '0 : r_col + CLW'(1);
        end
        put_scroll = put_nxt >= (AW+1)'(CELL_COUNT);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.kind)
                        KIND_PUT:  n_state = put_scroll ? ST_SHIFT : ST_DONE;
                        KIND_SET:  n_state = pos_ok ? ST_SPLIT : ST_DONE;
                        KIND_READ: n_state = pos_ok ? ST_READ : ST_DONE;
                        KIND_NONE: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SPLIT: begin
                if (split_done) n_state = ST_DONE;
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_SHIFT: begin
                if (r_addr == SHIFT_END) n_state = ST_ZERO;
            end
            ST_ZERO: begin
                if (r_addr == LAST_ADDR) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = BLANK_CHAR;
        ram_re      = 1'b0;
        ram_raddr   = pos_addr;
        split_start = 1'b0;
        unique case (r_state)
            ST_CLEAR, ST_ZERO: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    ram_we      = (i_in_item.kind == KIND_PUT) && !is_newline;
                    ram_waddr   = r_cur;
                    ram_wdata   = i_in_item.character;
                    ram_re      = (i_in_item.kind == KIND_READ) && pos_ok;
                    split_start = (i_in_item.kind == KIND_SET) && pos_ok;
                end
            end
            ST_SHIFT: begin
                ram_re    = r_addr != SHIFT_END;
                ram_raddr = AW'({1'b0, r_addr} + (AW+1)'(COLUMNS));
                ram_we    = r_addr != '0;
                ram_waddr = r_addr - AW'(1);
                ram_wdata = ram_rdata;
            end
            ST_SPLIT, ST_READ, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_cur       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR, ST_ZERO: begin
                    r_addr <= r_addr + AW'(1);
                end
                ST_SHIFT: begin
                    if (r_addr != SHIFT_END) r_addr <= r_addr + AW'(1);
                end
                ST_IDLE: begin
                    if (accept && i_in_item.kind == KIND_PUT) begin
                        if (put_scroll) begin
                            r_cur  <= BOTTOM;
                            r_col  <= '0;
                            r_addr <= '0;
                        end else begin
                            r_cur <= put_nxt[AW-1:0];
                            r_col <= put_col;
                        end
                    end
                end
                ST_SPLIT: begin
                    if (split_done) begin
                        r_cur <= r_pos;
                        r_col <= split_col;
                    end
                end
                ST_READ, ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos  <= pos_addr;
            r_data <= BLANK_CHAR;
            r_scr  <= (i_in_item.kind == KIND_PUT) && put_scroll;
            r_bad  <= (i_in_item.kind == KIND_SET || i_in_item.kind == KIND_READ) && !pos_ok;
        end
        if (r_state == ST_READ) begin
            r_data <= ram_rdata;
        end
        if (out_load) begin
            r_out_item.cursor       <= cur_wide[POS_W-1:0];
            r_out_item.cell_data    <= r_data;
            r_out_item.scrolled     <= r_scr;
            r_out_item.bad_position <= r_bad;
        end
    end

    assign cur_wide    = {{POS_W{1'b0}}, r_cur};
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    tccs_screen_ram #(
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tccs_col_split #(
        .COLUMNS (COLUMNS)
    ) u_split (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (split_start),
        .i_position (i_in_item.position),
        .o_done     (split_done),
        .o_col      (split_col)
    );

endmodule

/* rtl/core/tccs_checker.sv */
// Port-level checks for text_console_cursor_scroll_core, attached by bind.
// Depends on tccs_pkg.
module tccs_checker
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    localparam logic [31:0] BOTTOM_W = 32'((ROWS - 1) * COLUMNS);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while another is in progress");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.scrolled |-> o_out_item.cursor == BOTTOM_W[POS_W-1:0])
        else $error("scroll left cursor off the bottom row start");

    a_bad_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.bad_position
            |-> o_out_item.cell_data == BLANK_CHAR && !o_out_item.scrolled)
        else $error("bad position item carries data or scroll");

endmodule

bind text_console_cursor_scroll_core tccs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
